[hw/rtl/utf8_text_validator_top_defines.svh]
// Assertion macros shared by the UTF-8 text validator RTL.
`ifndef UTF8_TEXT_VALIDATOR_TOP_DEFINES_SVH
`define UTF8_TEXT_VALIDATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define UTF8TV_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define UTF8TV_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define UTF8TV_ASSERT_NOW(lbl, cond, prop, msg)
`define UTF8TV_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

[hw/rtl/utf8tv_pkg.sv]
// Types and constants of the UTF-8 text validator.
package utf8tv_pkg;

    localparam int LIMIT_W = 10;
    localparam int COUNT_W = LIMIT_W + 1;

    localparam logic [LIMIT_W-1:0] MAX_TEXT_RESET = 10'd64;

    localparam logic [7:0] BYTE_TAB      = 8'h09;
    localparam logic [7:0] BYTE_LF       = 8'h0a;
    localparam logic [7:0] BYTE_CR       = 8'h0d;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_DEL      = 8'h7f;
    localparam logic [7:0] LEAD2_LO      = 8'hc2;
    localparam logic [7:0] LEAD2_HI      = 8'hdf;
    localparam logic [7:0] LEAD3_LO      = 8'he0;
    localparam logic [7:0] LEAD3_SURR    = 8'hed;
    localparam logic [7:0] LEAD3_HI      = 8'hef;
    localparam logic [7:0] LEAD4_LO      = 8'hf0;
    localparam logic [7:0] LEAD4_HI      = 8'hf4;
    localparam logic [7:0] CONT_MIN_A0   = 8'ha0;
    localparam logic [7:0] CONT_MAX_9F   = 8'h9f;
    localparam logic [7:0] CONT_MIN_90   = 8'h90;
    localparam logic [7:0] CONT_MAX_8F   = 8'h8f;

    // Limit on the byte that follows a lead byte.
    typedef enum logic [2:0] {
        RULE_NONE   = 3'd0,
        RULE_MIN_A0 = 3'd1,
        RULE_MAX_9F = 3'd2,
        RULE_MIN_90 = 3'd3,
        RULE_MAX_8F = 3'd4
    } rule_t;

    typedef struct packed {
        logic [1:0]         cont_left;
        rule_t              rule;
        logic [COUNT_W-1:0] bytes_seen;
        logic               error_seen;
    } str_state_t;

    typedef struct packed {
        logic               text_valid;
        logic [COUNT_W-1:0] byte_count;
    } result_t;

endpackage

[hw/rtl/utf8tv_ifs.sv]
// Stream interfaces for the byte words and the verdict words.
interface utf8tv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       carries_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output carries_byte, output is_last,
                    input ready);
    modport sink (input valid, input text_byte, input carries_byte, input is_last,
                  output ready);
endinterface

interface utf8tv_out_if;
    logic                             valid;
    logic                             ready;
    logic                             text_valid;
    logic [utf8tv_pkg::COUNT_W-1:0]   byte_count;

    modport source (output valid, output text_valid, output byte_count, input ready);
    modport sink (input valid, input text_valid, input byte_count, output ready);
endinterface

[hw/rtl/utf8tv_step.sv]
// Per-byte UTF-8 check: next string state and the verdict of a closing word.
module utf8tv_step (
    input  utf8tv_pkg::str_state_t              cur,
    input  logic [7:0]                          text_byte,
    input  logic                                carries_byte,
    input  logic                                is_last,
    input  logic [utf8tv_pkg::LIMIT_W-1:0]      max_text_bytes,
    output utf8tv_pkg::str_state_t              nxt,
    output utf8tv_pkg::result_t                 result
);
    import utf8tv_pkg::*;

    logic [COUNT_W-1:0] cap;
    logic [COUNT_W-1:0] limit_ext;
    logic               cont_ok;
    logic               ctrl_bad;
    str_state_t         upd;

    assign limit_ext = {1'b0, max_text_bytes};
    assign cap       = limit_ext + COUNT_W'(1);

    always_comb
    begin
        case (cur.rule)
            RULE_MIN_A0: cont_ok = text_byte >= CONT_MIN_A0;
            RULE_MAX_9F: cont_ok = text_byte <= CONT_MAX_9F;
            RULE_MIN_90: cont_ok = text_byte >= CONT_MIN_90;
            RULE_MAX_8F: cont_ok = text_byte <= CONT_MAX_8F;
            default:     cont_ok = 1'b1;
        endcase
        cont_ok = cont_ok && (text_byte[7:6] == 2'b10);
    end

    assign ctrl_bad = (text_byte == BYTE_DEL) ||
                      ((text_byte < BYTE_SPACE) && (text_byte != BYTE_TAB) &&
                       (text_byte != BYTE_LF) && (text_byte != BYTE_CR));

    always_comb
    begin
        upd = cur;
        if (cur.bytes_seen < cap)
        begin
            upd.bytes_seen = cur.bytes_seen + COUNT_W'(1);
        end
        if (cur.cont_left != 2'd0)
        begin
            upd.error_seen = cur.error_seen | ~cont_ok;
            upd.rule       = RULE_NONE;
            upd.cont_left  = cur.cont_left - 2'd1;
        end
        else if (!text_byte[7])
        begin
            upd.error_seen = cur.error_seen | ctrl_bad;
        end
        else
        begin
            upd.rule = RULE_NONE;
            if ((text_byte >= LEAD2_LO) && (text_byte <= LEAD2_HI))
            begin
                upd.cont_left = 2'd1;
            end
            else if ((text_byte >= LEAD3_LO) && (text_byte <= LEAD3_HI))
            begin
                upd.cont_left = 2'd2;
                if (text_byte == LEAD3_LO)
                begin
                    upd.rule = RULE_MIN_A0;
                end
                else if (text_byte == LEAD3_SURR)
                begin
                    upd.rule = RULE_MAX_9F;
                end
            end
            else if ((text_byte >= LEAD4_LO) && (text_byte <= LEAD4_HI))
            begin
                upd.cont_left = 2'd3;
                if (text_byte == LEAD4_LO)
                begin
                    upd.rule = RULE_MIN_90;
                end
                else if (text_byte == LEAD4_HI)
                begin
                    upd.rule = RULE_MAX_8F;
                end
            end
            else
            begin
                upd.error_seen = 1'b1;
            end
        end
        if (!carries_byte)
        begin
            upd = cur;
        end
    end

    always_comb
    begin
        result.text_valid = !upd.error_seen && (upd.cont_left == 2'd0) &&
                            (upd.bytes_seen != '0) && (upd.bytes_seen <= limit_ext);
        result.byte_count = upd.bytes_seen;
        if (is_last)
        begin
            nxt = '{cont_left: 2'd0, rule: RULE_NONE, bytes_seen: '0, error_seen: 1'b0};
        end
        else
        begin
            nxt = upd;
        end
    end

endmodule

[hw/rtl/utf8tv_out_stage.sv]
// Result register that holds a verdict word until the receiver takes it.
`include "utf8_text_validator_top_defines.svh"
module utf8tv_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  utf8tv_pkg::result_t  result_next,
    output logic                 can_load,
    utf8tv_out_if.source         res
);
    import utf8tv_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || res.ready;
    assign valid_next = load || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign res.valid      = valid_reg;
    assign res.text_valid = result_reg.text_valid;
    assign res.byte_count = result_reg.byte_count;

    `UTF8TV_ASSERT_NOW(a_no_overwrite, load, can_load, "verdict loaded over an untaken one")
    `UTF8TV_ASSERT_NOW(a_rise_from_load, $rose(valid_reg), $past(load),
                       "verdict appeared without a load")

endmodule

[hw/rtl/utf8_text_validator_top.sv]
// Top level of the strict UTF-8 text validator.
//
// Byte words enter on text_in (valid/ready), one byte of the string per word.
// A word with carries_byte low adds no byte; a word with is_last high closes
// the string and produces exactly one verdict word on result_out: text_valid
// and byte_count, the count saturating one above the configured limit.
// The limit is set through cfg_wr_en/cfg_wr_data and should be written only
// while no string is in flight; it resets to 64 bytes.
// An accepted word lands in an input register; from there the UTF-8 check
// updates the string state and, for a closing word, fills the result
// register once that is free. A verdict is held in the result register
// until taken. The block sustains one word per cycle while no closing word
// waits, a rate set by the state update between the two registers.
// When result_out is stalled, ordinary byte words keep flowing; only a
// closing word waits in the input register until the held verdict is taken,
// and text_in.ready then falls. Reset empties both registers, clears the
// string state and restores the limit.
`include "utf8_text_validator_top_defines.svh"
module utf8_text_validator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [utf8tv_pkg::LIMIT_W-1:0]    cfg_wr_data,
    utf8tv_in_if.sink                         text_in,
    utf8tv_out_if.source                      result_out
);
    import utf8tv_pkg::*;

    // Configured length limit.
    logic [LIMIT_W-1:0] max_text_reg;

    // Input register: the word waiting for its state update.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_carries_reg;
    logic       in_last_reg;

    // String state carried from byte to byte.
    str_state_t state_reg;
    str_state_t state_next;
    str_state_t step_state;
    result_t    step_result;

    logic can_load;
    logic advance;
    logic accept;

    // A closing word may only move on when the result register is free.
    assign advance       = in_valid_reg && (!in_last_reg || can_load);
    assign text_in.ready = !in_valid_reg || advance;
    assign accept        = text_in.valid && text_in.ready;
    assign in_valid_next = accept || (in_valid_reg && !advance);
    assign state_next    = advance ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_text_reg <= MAX_TEXT_RESET;
            in_valid_reg <= 1'b0;
            state_reg    <= '{cont_left: 2'd0, rule: RULE_NONE, bytes_seen: '0,
                              error_seen: 1'b0};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_text_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg    <= text_in.text_byte;
            in_carries_reg <= text_in.carries_byte;
            in_last_reg    <= text_in.is_last;
        end
    end

    utf8tv_step u_step (
        .cur            (state_reg),
        .text_byte      (in_byte_reg),
        .carries_byte   (in_carries_reg),
        .is_last        (in_last_reg),
        .max_text_bytes (max_text_reg),
        .nxt            (step_state),
        .result         (step_result)
    );

    utf8tv_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && in_last_reg),
        .result_next (step_result),
        .can_load    (can_load),
        .res         (result_out)
    );

    // A second-byte rule only exists while at least two continuations are owed.
    `UTF8TV_ASSERT_NOW(a_rule_needs_cont, state_reg.rule != RULE_NONE,
                       state_reg.cont_left >= 2'd2, "second-byte rule without a sequence")
    // Closing a string must leave a clean state for the next one.
    `UTF8TV_ASSERT_NEXT(a_close_clears, advance && in_last_reg,
                        (state_reg.bytes_seen == '0) && !state_reg.error_seen &&
                        (state_reg.cont_left == 2'd0), "string state not cleared at close")
    // An empty input register never blocks the sender.
    `UTF8TV_ASSERT_NOW(a_empty_ready, !in_valid_reg, text_in.ready,
                       "input register empty but not ready")

endmodule

[sim/utf8_text_validator_top_test.sv]
// Self-checking testbench of the UTF-8 text validator top level.
`timescale 1ns / 100ps

module utf8_text_validator_top_test;

    import utf8tv_pkg::*;

    // Generous ceiling on the run length.
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Kinds of random string: clean text, clean text with one defect, or raw bytes.
    typedef enum {STYLE_CLEAN, STYLE_BROKEN, STYLE_NOISE} text_style_t;

    // Defects that a broken string receives.
    typedef enum {HARM_REPLACE, HARM_CUT, HARM_LONE_LEAD, HARM_BAD_SECOND} text_harm_t;

    // Verdict scoreboard. It tracks the decoder state of the open string, queues the
    // expected verdict of every closing word and compares the verdicts that come out.
    class utf8_verdict_board;
        logic [LIMIT_W-1:0] limit;
        logic [1:0]         owed;
        rule_t              pending_rule;
        logic [COUNT_W-1:0] seen;
        bit                 bad;
        result_t            verdicts_due[$];
        int                 mismatches;

        function new();
            limit = MAX_TEXT_RESET;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            owed = 2'd0;
            pending_rule = RULE_NONE;
            seen = '0;
            bad = 1'b0;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        // Called for every word accepted on the input side.
        function void note_word(logic [7:0] b, logic carries, logic last);
            result_t verdict;
            logic    ok;
            if (carries)
            begin
                if (seen <= COUNT_W'(limit))
                    seen = seen + 1'b1;
                if (owed != 2'd0)
                begin
                    ok = (b[7:6] == 2'b10);
                    case (pending_rule)
                        RULE_MIN_A0: ok = ok && (b >= CONT_MIN_A0);
                        RULE_MAX_9F: ok = ok && (b <= CONT_MAX_9F);
                        RULE_MIN_90: ok = ok && (b >= CONT_MIN_90);
                        RULE_MAX_8F: ok = ok && (b <= CONT_MAX_8F);
                        default: ;
                    endcase
                    if (!ok)
                        bad = 1'b1;
                    pending_rule = RULE_NONE;
                    owed = owed - 1'b1;
                end
                else if (b <= BYTE_DEL)
                begin
                    if (b == BYTE_DEL ||
                        (b < BYTE_SPACE && b != BYTE_TAB && b != BYTE_LF && b != BYTE_CR))
                        bad = 1'b1;
                end
                else
                begin
                    pending_rule = RULE_NONE;
                    if (b >= LEAD2_LO && b <= LEAD2_HI)
                        owed = 2'd1;
                    else if (b >= LEAD3_LO && b <= LEAD3_HI)
                    begin
                        owed = 2'd2;
                        if (b == LEAD3_LO)
                            pending_rule = RULE_MIN_A0;
                        else if (b == LEAD3_SURR)
                            pending_rule = RULE_MAX_9F;
                    end
                    else if (b >= LEAD4_LO && b <= LEAD4_HI)
                    begin
                        owed = 2'd3;
                        if (b == LEAD4_LO)
                            pending_rule = RULE_MIN_90;
                        else if (b == LEAD4_HI)
                            pending_rule = RULE_MAX_8F;
                    end
                    else
                        bad = 1'b1;
                end
            end
            if (last)
            begin
                verdict.text_valid = !bad && owed == 2'd0 && seen != '0 &&
                                     seen <= COUNT_W'(limit);
                verdict.byte_count = seen;
                verdicts_due.push_back(verdict);
                clear_string();
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 50)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Called for every verdict word taken from the output side.
        task check_verdict(logic text_valid, logic [COUNT_W-1:0] byte_count);
            result_t want;
            if (verdicts_due.size() == 0)
            begin
                report_mismatch($sformatf("verdict valid=%0b count=%0d with none due",
                                          text_valid, byte_count));
                return;
            end
            want = verdicts_due.pop_front();
            if (text_valid !== want.text_valid)
                report_mismatch($sformatf("text_valid %0b, expected %0b (count %0d)",
                                          text_valid, want.text_valid, want.byte_count));
            if (byte_count !== want.byte_count)
                report_mismatch($sformatf("byte_count %0d, expected %0d",
                                          byte_count, want.byte_count));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LIMIT_W-1:0]  cfg_wr_data;

    utf8tv_in_if  text_if ();
    utf8tv_out_if verdict_if ();

    utf8_verdict_board board = new();

    // Bytes of the string about to be sent.
    logic [7:0] text_bytes[$];

    // Counts words that carry a byte or close a string; ignored words are left out.
    int          words_sent = 0;
    // While set, neither side idles.
    bit          no_idle = 1'b0;
    // A non-zero value asks the receiver to hold off; the value sets the length of the hold.
    int          hold_request = 0;
    int unsigned cycle_count = 0;

    utf8_text_validator_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text_in     (text_if),
        .result_out  (verdict_if)
    );

    // 8 ns clock, starting low.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog: a run that hangs, or that never delivers an expected verdict, ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Both handshakes are observed at the rising edge. Inputs only move at the falling
    // edge, so the values seen here are the ones the block itself acts on.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (text_if.valid && text_if.ready)
                board.note_word(text_if.text_byte, text_if.carries_byte, text_if.is_last);
            if (verdict_if.valid && verdict_if.ready)
                board.check_verdict(verdict_if.text_valid, verdict_if.byte_count);
        end
    end

    // Receiver. It stalls at random in roughly a quarter of the cycles, never while
    // no_idle is set, and holds ready low for a whole stretch when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        verdict_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                verdict_if.ready <= 1'b0;
            end
            else
                verdict_if.ready <= no_idle || ($urandom_range(0, 99) >= 27);
        end
    end

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hbf));
    endfunction

    // Offers one word and returns at the falling edge after it has been accepted.
    // It is entered at a falling edge; valid is lowered only for a gap, so a word
    // that follows directly keeps valid high without a glitch.
    task automatic send_word(logic [7:0] b, logic carries, logic last);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 18)
        begin
            gap = $urandom_range(1, 3);
            text_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.text_byte <= b;
        text_if.carries_byte <= carries;
        text_if.is_last <= last;
        if (carries || last)
            words_sent++;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Fills text_bytes with a string of the given style. Clean text is built from
    // whole characters, so it may run up to three bytes past the drawn length.
    task automatic build_text(text_style_t style, int min_len, int max_len);
        int         target;
        int         pos;
        logic [7:0] lead;
        text_harm_t harm;
        text_bytes.delete();
        target = $urandom_range(min_len, max_len);
        if (style == STYLE_NOISE)
        begin
            repeat (target) text_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        while (text_bytes.size() < target)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 2))
                        0: text_bytes.push_back(BYTE_TAB);
                        1: text_bytes.push_back(BYTE_LF);
                        default: text_bytes.push_back(BYTE_CR);
                    endcase
                end
                1, 2, 3, 4: text_bytes.push_back(8'($urandom_range(BYTE_SPACE, BYTE_DEL - 1)));
                5, 6:
                begin
                    text_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
                    text_bytes.push_back(cont_byte());
                end
                7, 8:
                begin
                    // The second byte respects the overlong and surrogate limits.
                    lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
                    text_bytes.push_back(lead);
                    if (lead == LEAD3_LO)
                        text_bytes.push_back(8'($urandom_range(CONT_MIN_A0, 8'hbf)));
                    else if (lead == LEAD3_SURR)
                        text_bytes.push_back(8'($urandom_range(8'h80, CONT_MAX_9F)));
                    else
                        text_bytes.push_back(cont_byte());
                    text_bytes.push_back(cont_byte());
                end
                default:
                begin
                    lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
                    text_bytes.push_back(lead);
                    if (lead == LEAD4_LO)
                        text_bytes.push_back(8'($urandom_range(CONT_MIN_90, 8'hbf)));
                    else if (lead == LEAD4_HI)
                        text_bytes.push_back(8'($urandom_range(8'h80, CONT_MAX_8F)));
                    else
                        text_bytes.push_back(cont_byte());
                    text_bytes.push_back(cont_byte());
                    text_bytes.push_back(cont_byte());
                end
            endcase
        end
        if (style == STYLE_BROKEN)
        begin
            harm = text_harm_t'($urandom_range(0, 3));
            case (harm)
                HARM_REPLACE:
                begin
                    pos = $urandom_range(0, text_bytes.size() - 1);
                    text_bytes[pos] = 8'($urandom_range(0, 255));
                end
                // Dropping the final byte usually leaves a multi-byte character cut off.
                HARM_CUT: void'(text_bytes.pop_back());
                HARM_LONE_LEAD: text_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD4_HI)));
                HARM_BAD_SECOND:
                begin
                    // A second byte just outside its limit, then complete continuations.
                    case ($urandom_range(0, 3))
                        0: text_bytes = {text_bytes, LEAD3_LO, CONT_MAX_9F, 8'h80};
                        1: text_bytes = {text_bytes, LEAD3_SURR, CONT_MIN_A0, 8'h80};
                        2: text_bytes = {text_bytes, LEAD4_LO, CONT_MAX_8F, 8'h80, 8'h80};
                        default: text_bytes = {text_bytes, LEAD4_HI, CONT_MIN_90, 8'h80, 8'h80};
                    endcase
                end
                default: ;
            endcase
        end
    endtask

    // Sends text_bytes as one string. Now and then an ignored word is slipped in,
    // and some strings are closed by a word that carries no byte.
    task automatic send_text();
        bit end_only;
        end_only = (text_bytes.size() == 0) || ($urandom_range(0, 9) == 0);
        foreach (text_bytes[i])
        begin
            if ($urandom_range(0, 24) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(text_bytes[i], 1'b1, !end_only && i == text_bytes.size() - 1);
        end
        if (end_only)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Random strings until the given number of further words has gone out. Most are
    // clean text so that the decoder reaches its multi-byte states; lengths stay short
    // apart from the odd longer string, capped at 80 drawn bytes, that can straddle a lower limit.
    task automatic run_random(int more);
        int stop;
        int max_len;
        int pick;
        stop = words_sent + more;
        while (words_sent < stop)
        begin
            if ($urandom_range(0, 9) == 0)
                max_len = (int'(board.limit) + 3 < 80) ? int'(board.limit) + 3 : 80;
            else
                max_len = 12;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                build_text(STYLE_CLEAN, 1, max_len);
            else if (pick < 90)
                build_text(STYLE_BROKEN, 1, max_len);
            else
                build_text(STYLE_NOISE, 0, max_len);
            send_text();
        end
    endtask

    // Sender pause: valid drops and the testbench waits until every verdict due has
    // arrived, then waits on for byte words still inside the block.
    task automatic wait_for_verdicts();
        text_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Only called while the block is idle, after wait_for_verdicts.
    task automatic set_limit(logic [LIMIT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.limit = value;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        text_if.valid = 1'b0;
        text_if.text_byte = 8'h00;
        text_if.carries_byte = 1'b0;
        text_if.is_last = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed strings under the reset limit of 64 bytes.
        // NUL, a lead byte above F4 and DEL, each alone.
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(BYTE_DEL, 1'b1, 1'b1);
        // The three permitted control bytes and the top printable byte: valid.
        send_word(BYTE_TAB, 1'b1, 1'b0);
        send_word(BYTE_LF, 1'b1, 1'b0);
        send_word(BYTE_CR, 1'b1, 1'b0);
        send_word(8'h7e, 1'b1, 1'b1);
        // An empty string.
        send_word(8'hff, 1'b0, 1'b1);
        // An ignored word, then a two-byte character closed by a word with no byte.
        send_word(8'h00, 1'b0, 1'b0);
        send_word(LEAD2_LO, 1'b1, 1'b0);
        send_word(8'hbf, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1);
        // Overlong three-byte form.
        send_word(LEAD3_LO, 1'b1, 1'b0);
        send_word(CONT_MAX_9F, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        // Surrogate.
        send_word(LEAD3_SURR, 1'b1, 1'b0);
        send_word(CONT_MIN_A0, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        // Code point beyond the Unicode range.
        send_word(LEAD4_HI, 1'b1, 1'b0);
        send_word(CONT_MIN_90, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        // A lead byte with its continuation cut off by the end of the string.
        send_word(8'hc3, 1'b1, 1'b1);

        run_random(180);

        // A stretch with no idling on either side.
        no_idle = 1'b1;
        run_random(100);
        no_idle = 1'b0;

        // The receiver holds off for a long while as short strings keep coming. A closing
        // word then waits behind the held verdict and the input stalls.
        hold_request = 300;
        repeat (40)
        begin
            build_text(STYLE_CLEAN, 1, 2);
            send_text();
        end
        wait_for_verdicts();
        run_random(100);
        wait_for_verdicts();

        // Smallest non-zero limit: only single-byte strings pass.
        set_limit(10'd1);
        run_random(100);
        wait_for_verdicts();

        // Largest limit, including one string long enough to saturate the count.
        set_limit(10'd1023);
        run_random(150);
        build_text(STYLE_CLEAN, 1026, 1026);
        send_text();
        wait_for_verdicts();

        // A limit of zero rejects every string.
        set_limit(10'd0);
        run_random(60);
        wait_for_verdicts();

        // Some limit in between.
        set_limit(10'($urandom_range(2, 200)));
        run_random(150);
        wait_for_verdicts();

        repeat (10) @(negedge clk);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/utf8tv_pkg.sv
hw/rtl/utf8tv_ifs.sv
hw/rtl/utf8tv_step.sv
hw/rtl/utf8tv_out_stage.sv
hw/rtl/utf8_text_validator_top.sv
sim/utf8_text_validator_top_test.sv
